@@ rtl/core/dlte_pkg.sv @@
// ----------------------------------------------------------------------------
// dlte_pkg
// Shared types, constants and helper functions of the dense layer engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dlte_pkg;

  localparam int DEF_MAX_FAN_IN  = 16;
  localparam int DEF_MAX_NEURONS = 16;

  localparam int DATA_W  = 16;
  localparam int PSUM_W  = 40;
  localparam int SLOPE_W = 13;
  localparam int TANH_W  = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [4:0] BIAS_INDEX = 5'd16;

  // register reset values
  localparam logic [15:0] RST_STEP_SIZE     = 16'd7;
  localparam logic [15:0] RST_MOMENTUM      = 16'd58982;
  localparam logic [15:0] RST_L2_ALPHA      = 16'd7;
  localparam logic [4:0]  RST_IN_USE        = 5'd16;
  localparam logic [4:0]  RST_OUT_USE       = 5'd16;

  typedef enum logic [1:0] {
    REQ_FWD   = 2'd0,
    REQ_UPD   = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_SIZE       = 3'd0,
    CFG_MOMENTUM        = 3'd1,
    CFG_L2_ALPHA        = 3'd2,
    CFG_ACTIVATION_KIND = 3'd3,
    CFG_INPUTS_IN_USE   = 3'd4,
    CFG_OUTPUTS_IN_USE  = 3'd5
  } cfg_idx_t;

  // tanh(k/4) in Q4.12, k = 0..32
  function automatic logic [TANH_W-1:0] tanh_point(input logic [5:0] k);
    logic [TANH_W-1:0] r;
    case (k)
      6'd0:  r = 13'd0;
      6'd1:  r = 13'd1003;
      6'd2:  r = 13'd1893;
      6'd3:  r = 13'd2602;
      6'd4:  r = 13'd3119;
      6'd5:  r = 13'd3475;
      6'd6:  r = 13'd3707;
      6'd7:  r = 13'd3856;
      6'd8:  r = 13'd3949;
      6'd9:  r = 13'd4006;
      6'd10: r = 13'd4041;
      6'd11: r = 13'd4062;
      6'd12: r = 13'd4076;
      6'd13: r = 13'd4084;
      6'd14: r = 13'd4089;
      6'd15: r = 13'd4091;
      6'd16: r = 13'd4093;
      6'd17: r = 13'd4094;
      6'd18: r = 13'd4095;
      6'd19: r = 13'd4095;
      default: r = 13'd4096;
    endcase
    return r;
  endfunction

  // saturate to signed 16 bits
  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [PSUM_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dense_layer_train_engine.sv @@
// ----------------------------------------------------------------------------
// dense_layer_train_engine
// Fully connected layer in Q4.12 with forward pass and momentum SGD update.
// ----------------------------------------------------------------------------
// Requests enter one at a time on the req channel; req_stall is high while a
// request is in work. Weights and weight velocities live in two synchronous
// memories (one read, one write port each); biases, bias velocities, the
// stored input vector and the per-neuron running sums sit in flip-flops.
// After reset a clearing pass over the MAX_FAN_IN*MAX_NEURONS entries zeroes
// the velocity memory; no request is taken meanwhile, configuration writes
// are. A forward element walks every neuron through the weight memory read
// port (no walk when its index is out of use and last is clear). The element
// marked last then emits one result per neuron in use, each through the PRE,
// TANH and EMIT states, EMIT holding until the result word is taken. An
// update walks the bias and the inputs in use through a read-modify-write
// pipe and ends with an acknowledgement word; a write is acknowledged
// directly. The result register decouples the sides: a new request is
// taken while a word waits.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_layer_train_engine #(
  parameter int MAX_FAN_IN  = dlte_pkg::DEF_MAX_FAN_IN,
  parameter int MAX_NEURONS = dlte_pkg::DEF_MAX_NEURONS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // configuration
  input  wire                                   cfg_write,
  input  wire [dlte_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [dlte_pkg::DATA_W-1:0]            cfg_data,
  // request channel
  input  wire                                   req_valid,
  output logic                                  req_stall,
  input  wire [1:0]                             req_type,
  input  wire [3:0]                             neuron_index,
  input  wire [4:0]                             input_index,
  input  wire signed [dlte_pkg::DATA_W-1:0]     value,
  input  wire                                   last,
  // result channel
  output logic                                  res_valid,
  input  wire                                   res_stall,
  output logic [3:0]                            neuron_index_res,
  output logic signed [dlte_pkg::DATA_W-1:0]    activation,
  output logic signed [dlte_pkg::DATA_W-1:0]    preactivation,
  output logic [dlte_pkg::SLOPE_W-1:0]          slope,
  output logic                                  last_res
);
  import dlte_pkg::*;

  localparam int DEPTH = MAX_FAN_IN * MAX_NEURONS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_FAN_IN > 1) ? $clog2(MAX_FAN_IN) : 1;
  localparam int NW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int CW_I  = $clog2(MAX_FAN_IN + 1);
  localparam int CW_N  = $clog2(MAX_NEURONS + 1);
  localparam int EW    = $clog2(MAX_FAN_IN + 2);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b00000001,
    ST_IDLE  = 8'b00000010,
    ST_FWD   = 8'b00000100,
    ST_PRE   = 8'b00001000,
    ST_TANH  = 8'b00010000,
    ST_EMIT  = 8'b00100000,
    ST_UPD   = 8'b01000000,
    ST_ACK   = 8'b10000000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] step_size, momentum, l2_alpha;
  logic        activation_kind;
  logic [4:0]  inputs_in_use, outputs_in_use;
  logic [CW_I-1:0] n_in;
  logic [CW_N-1:0] n_out;

  // memories and flip-flop stores
  logic signed [DATA_W-1:0] wmem [DEPTH];
  logic signed [DATA_W-1:0] vmem [DEPTH];
  logic signed [DATA_W-1:0] w_rdata, v_rdata;
  logic signed [DATA_W-1:0] bias_store    [MAX_NEURONS];
  logic signed [DATA_W-1:0] bias_velocity [MAX_NEURONS];
  logic signed [DATA_W-1:0] input_store   [MAX_FAN_IN];
  logic signed [PSUM_W-1:0] partial_sums  [MAX_NEURONS];

  // request context
  logic signed [DATA_W-1:0] x_reg;
  logic                     last_reg;
  logic [3:0]               neuron_reg;
  logic [IW-1:0]            idx_reg;
  logic [NW-1:0]            nb;

  logic req_accept, out_free, out_load;
  logic fwd_in_use, upd_in_use, wr_neuron_ok;

  // memory ports
  logic          w_we, v_we;
  logic [AW-1:0] w_waddr, v_waddr, w_raddr, fwd_addr, upd_addr, wr_addr, clr_addr;
  logic signed [DATA_W-1:0] w_wdata, v_wdata;

  // forward walk
  logic [CW_N-1:0]          n_iss;
  logic                     fwd_issue, p1v, p2v;
  logic [NW-1:0]            p1n, p2n;
  logic signed [31:0]       prod2;

  // result pass
  logic [NW-1:0]            fn;
  logic                     fn_last;
  logic signed [PSUM_W-1:0] pre_sum;
  logic signed [DATA_W-1:0] pre_reg;
  logic signed [16:0]       a17;
  logic [14:0]              a15;
  logic [TANH_W-1:0]        t_lo, t_hi, t_diff, t_next, t_reg;
  logic [23:0]              t_ip;
  logic [25:0]              tt;
  logic signed [DATA_W-1:0] act_out;
  logic [SLOPE_W-1:0]       slope_out;

  // update pipe
  logic [EW-1:0]            e_iss;
  logic                     upd_issue, upd_busy;
  logic                     u1v, u2v, u3v, u4v, u5v, u6v;
  logic                     u1b, u2b, u3b, u4b, u5b, u6b;
  logic [AW-1:0]            u1a, u2a, u3a, u4a, u5a, u6a;
  logic [IW-1:0]            u1j;
  logic signed [DATA_W-1:0] s1_p, s1_v, s1_x;
  logic signed [DATA_W-1:0] u2p, u3p, u4p, u5p, u6p;
  logic signed [DATA_W-1:0] u2vel, u3vel;
  logic signed [31:0]       u2gx;
  logic signed [35:0]       u3g;
  logic signed [33:0]       u3ap, u4mv, u5mv;
  logic signed [36:0]       u4sum;
  logic signed [53:0]       u5lrs;
  logic signed [55:0]       t56;
  logic signed [DATA_W-1:0] u6step, pnew;

  // ---------------------------------------------------------------------------
  // Clamp the count registers into their legal ranges.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (inputs_in_use == 5'd0) begin
      n_in = CW_I'(1);
    end else if (32'(inputs_in_use) > MAX_FAN_IN) begin
      n_in = CW_I'(MAX_FAN_IN);
    end else begin
      n_in = CW_I'(inputs_in_use);
    end
    if (outputs_in_use == 5'd0) begin
      n_out = CW_N'(1);
    end else if (32'(outputs_in_use) > MAX_NEURONS) begin
      n_out = CW_N'(MAX_NEURONS);
    end else begin
      n_out = CW_N'(outputs_in_use);
    end
  end

  // Handshake: take a request only in idle; the result register frees when
  // empty or taken this cycle.
  assign req_stall    = (state != ST_IDLE);
  assign req_accept   = req_valid && !req_stall;
  assign out_free     = !res_valid || !res_stall;
  assign out_load     = ((state == ST_EMIT) || (state == ST_ACK)) && out_free;

  assign fwd_in_use   = ({1'b0, input_index} < 6'(n_in));
  assign upd_in_use   = (32'(neuron_index) < 32'(n_out));
  assign wr_neuron_ok = (32'(neuron_index) < MAX_NEURONS);
  assign nb           = NW'(neuron_reg);

  // Address generation: weight (n, j) sits at n*MAX_FAN_IN + j.
  assign fwd_addr  = AW'(32'(n_iss) * MAX_FAN_IN + 32'(idx_reg));
  assign upd_addr  = AW'(32'(neuron_reg) * MAX_FAN_IN + 32'(e_iss) - 32'd1);
  assign wr_addr   = AW'(32'(neuron_index) * MAX_FAN_IN + 32'(input_index));
  assign fwd_issue = (state == ST_FWD) && (n_iss < CW_N'(MAX_NEURONS));
  assign upd_issue = (state == ST_UPD) && (e_iss <= EW'(n_in));
  assign upd_busy  = upd_issue || u1v || u2v || u3v || u4v || u5v || u6v;

  // ---------------------------------------------------------------------------
  // Memory port muxing. The walk of one request touches each entry once, so
  // reads and write-backs never collide on one entry.
  // ---------------------------------------------------------------------------
  always_comb begin
    w_we    = (req_accept && (req_type == REQ_WRITE) && wr_neuron_ok &&
               (32'(input_index) < MAX_FAN_IN)) || (u6v && !u6b);
    w_waddr = u6v ? u6a : wr_addr;
    w_wdata = u6v ? pnew : value;
    w_raddr = (state == ST_FWD) ? fwd_addr : upd_addr;
    v_we    = (state == ST_CLEAR) || (u6v && !u6b && (momentum != 16'd0));
    v_waddr = (state == ST_CLEAR) ? clr_addr : u6a;
    v_wdata = (state == ST_CLEAR) ? '0 : u6step;
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rdata <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    v_rdata <= vmem[upd_addr];
  end

  // ---------------------------------------------------------------------------
  // Result pass arithmetic: round and saturate the sum, then interpolate tanh
  // on |z| and build activation and slope.
  // ---------------------------------------------------------------------------
  always_comb begin
    pre_sum = partial_sums[fn] + (PSUM_W'(bias_store[fn]) <<< 12) + 40'sd2048;

    a17    = pre_reg[DATA_W-1] ? (17'sd0 - 17'(pre_reg)) : 17'(pre_reg);
    a15    = (a17 > 17'sd32767) ? 15'h7fff : a17[14:0];
    t_lo   = tanh_point({1'b0, a15[14:10]});
    t_hi   = tanh_point(6'({1'b0, a15[14:10]}) + 6'd1);
    t_diff = t_hi - t_lo;
    t_ip   = 24'(t_diff) * 24'(a15[9:0]) + 24'd512;
    t_next = t_lo + t_ip[22:10];

    tt = 26'(t_reg) * 26'(t_reg) + 26'd2048;
    if (activation_kind) begin
      act_out   = pre_reg[DATA_W-1] ? (16'sd0 - 16'(t_reg)) : 16'(t_reg);
      slope_out = 13'(14'd4096 - tt[25:12]);
    end else begin
      act_out   = (pre_reg > 16'sd0) ? pre_reg : '0;
      slope_out = (pre_reg > 16'sd0) ? 13'd4096 : 13'd0;
    end
    fn_last = ((CW_N'(fn) + CW_N'(1)) == n_out);
  end

  // ---------------------------------------------------------------------------
  // Update pipe, at most one multiplier per stage:
  //   s1 select operands, s2 x*delta, s3 alpha*p, s4 sum and momentum*v,
  //   s5 lr*sum, s6 round and saturate the step, then write back.
  // The bias rides first with input 4096, so its gradient is delta at Q.28.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_p = u1b ? bias_store[nb]    : w_rdata;
    s1_v = u1b ? bias_velocity[nb] : v_rdata;
    s1_x = u1b ? 16'sd4096         : input_store[u1j];
    t56  = 56'(u5lrs) + (56'(u5mv) <<< 16) + 56'sd2147483648;
    pnew = sat16(40'(u6p) - 40'(u6step));
  end

  // ---------------------------------------------------------------------------
  // Control and state with reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clr_addr        <= '0;
      step_size       <= RST_STEP_SIZE;
      momentum        <= RST_MOMENTUM;
      l2_alpha        <= RST_L2_ALPHA;
      activation_kind <= 1'b0;
      inputs_in_use   <= RST_IN_USE;
      outputs_in_use  <= RST_OUT_USE;
      n_iss           <= '0;
      e_iss           <= '0;
      fn              <= '0;
      p1v             <= 1'b0;
      p2v             <= 1'b0;
      {u1v, u2v, u3v, u4v, u5v, u6v} <= '0;
      res_valid       <= 1'b0;
      for (int i = 0; i < MAX_NEURONS; i++) begin
        partial_sums[i]  <= '0;
        bias_velocity[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_STEP_SIZE:       step_size       <= cfg_data;
          CFG_MOMENTUM:        momentum        <= cfg_data;
          CFG_L2_ALPHA:        l2_alpha        <= cfg_data;
          CFG_ACTIVATION_KIND: activation_kind <= cfg_data[0];
          CFG_INPUTS_IN_USE:   inputs_in_use   <= cfg_data[4:0];
          CFG_OUTPUTS_IN_USE:  outputs_in_use  <= cfg_data[4:0];
          default: ;
        endcase
      end

      // advance both walks' valid lines
      p1v <= fwd_issue;
      p2v <= p1v;
      u1v <= upd_issue;
      u2v <= u1v;
      u3v <= u2v;
      u4v <= u3v;
      u5v <= u4v;
      u6v <= u5v;

      if (p2v) begin
        partial_sums[p2n] <= partial_sums[p2n] + PSUM_W'(prod2);
      end
      if (u6v && u6b && (momentum != 16'd0)) begin
        bias_velocity[nb] <= u6step;
      end

      if (out_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_accept) begin
            n_iss <= '0;
            e_iss <= '0;
            fn    <= '0;
            unique case (req_t'(req_type))
              REQ_FWD: begin
                if (fwd_in_use) begin
                  state <= ST_FWD;
                end else if (last) begin
                  state <= ST_PRE;
                end
              end
              REQ_UPD:   state <= upd_in_use ? ST_UPD : ST_ACK;
              REQ_WRITE: state <= ST_ACK;
              default: ;
            endcase
          end
        end
        ST_FWD: begin
          if (fwd_issue) begin
            n_iss <= n_iss + CW_N'(1);
          end else if (!p1v && !p2v) begin
            state <= last_reg ? ST_PRE : ST_IDLE;
          end
        end
        ST_PRE:  state <= ST_TANH;
        ST_TANH: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            if (fn_last) begin
              state <= ST_IDLE;
              for (int i = 0; i < MAX_NEURONS; i++) begin
                partial_sums[i] <= '0;
              end
            end else begin
              fn    <= fn + NW'(1);
              state <= ST_PRE;
            end
          end
        end
        ST_UPD: begin
          if (upd_issue) begin
            e_iss <= e_iss + EW'(1);
          end else if (!upd_busy) begin
            state <= ST_ACK;
          end
        end
        ST_ACK: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers (no reset)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (req_accept) begin
      x_reg      <= value;
      last_reg   <= last;
      neuron_reg <= neuron_index;
      idx_reg    <= IW'(input_index);
      if ((req_type == REQ_FWD) && fwd_in_use) begin
        input_store[IW'(input_index)] <= value;
      end
      if ((req_type == REQ_WRITE) && wr_neuron_ok && (input_index == BIAS_INDEX)) begin
        bias_store[NW'(neuron_index)] <= value;
      end
    end
    if (u6v && u6b) begin
      bias_store[nb] <= pnew;
    end

    // forward walk
    p1n   <= NW'(n_iss);
    p2n   <= p1n;
    prod2 <= 32'(w_rdata) * 32'(x_reg);

    // result pass
    if (state == ST_PRE) begin
      pre_reg <= sat16(pre_sum >>> 12);
    end
    if (state == ST_TANH) begin
      t_reg <= t_next;
    end

    // update pipe
    u1b   <= (e_iss == '0);
    u1a   <= upd_addr;
    u1j   <= IW'(e_iss - EW'(1));
    u2b   <= u1b;
    u2a   <= u1a;
    u2p   <= s1_p;
    u2vel <= s1_v;
    u2gx  <= 32'(s1_x) * 32'(x_reg);
    u3b   <= u2b;
    u3a   <= u2a;
    u3p   <= u2p;
    u3vel <= u2vel;
    u3g   <= 36'(u2gx) <<< 4;
    u3ap  <= 34'($signed({1'b0, l2_alpha})) * 34'(u2p);
    u4b   <= u3b;
    u4a   <= u3a;
    u4p   <= u3p;
    u4sum <= 37'(u3g) + 37'(u3ap);
    u4mv  <= 34'($signed({1'b0, momentum})) * 34'(u3vel);
    u5b   <= u4b;
    u5a   <= u4a;
    u5p   <= u4p;
    u5lrs <= 54'($signed({1'b0, step_size})) * 54'(u4sum);
    u5mv  <= u4mv;
    u6b   <= u5b;
    u6a   <= u5a;
    u6p   <= u5p;
    u6step <= sat16(40'(t56 >>> 32));

    // result word
    if (out_load) begin
      if (state == ST_EMIT) begin
        neuron_index_res <= 4'(fn);
        activation       <= act_out;
        preactivation    <= pre_reg;
        slope            <= slope_out;
        last_res         <= fn_last;
      end else begin
        neuron_index_res <= neuron_reg;
        activation       <= '0;
        preactivation    <= '0;
        slope            <= '0;
        last_res         <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !res_valid)
    else $error("result issued during velocity clearing pass");

  a_fwd_pipe: assert property (@(posedge clk) disable iff (rst)
    p2v |-> (state == ST_FWD))
    else $error("forward accumulate outside forward walk");

  a_upd_pipe: assert property (@(posedge clk) disable iff (rst)
    u6v |-> (state == ST_UPD))
    else $error("update write-back outside update walk");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(preactivation)))
    else $error("stalled result word lost or changed");
`endif

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dense layer training engine: loads every weight
// and bias, runs a directed table, then random phases under several register
// settings, and compares each result word with an in-bench layer predictor.
// ----------------------------------------------------------------------------

module testbench;
  import dlte_pkg::*;

  typedef struct {
    logic [3:0]         neuron;
    logic signed [15:0] act;
    logic signed [15:0] pre;
    logic [12:0]        slp;
    logic               fin;
  } layer_out_t;

  typedef struct {
    req_t               kind;
    logic [3:0]         neuron;
    logic [4:0]         idx;
    logic signed [15:0] val;
    logic               fin;
    bit                 typed;  // expected ack typed in the table, not predicted
  } layer_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] req_type = '0;
  logic [3:0] neuron_index = '0;
  logic [4:0] input_index = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic last = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [3:0] neuron_index_res;
  logic signed [DATA_W-1:0] activation;
  logic signed [DATA_W-1:0] preactivation;
  logic [SLOPE_W-1:0] slope;
  logic last_res;

  dense_layer_train_engine u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .neuron_index(neuron_index), .input_index(input_index), .value(value),
    .last(last),
    .res_valid(res_valid), .res_stall(res_stall),
    .neuron_index_res(neuron_index_res), .activation(activation),
    .preactivation(preactivation), .slope(slope), .last_res(last_res)
  );

  always #1 clk = ~clk;

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Layer predictor: its own copy of the parameters, velocities and sums.
  // --------------------------------------------------------------------------
  int     wt[256], wt_vel[256], bias[16], bias_vel[16], in_vec[16];
  longint acc[16];
  int     lr_q16 = 7, mom_q16 = 58982, l2_q16 = 7, act_kind = 0;
  int     n_in_reg = 16, n_out_reg = 16;

  int tanh_pts[33] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949, 4006,
                       4041, 4062, 4076, 4084, 4089, 4091, 4093, 4094, 4095,
                       4095, 4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
                       4096, 4096, 4096, 4096, 4096};

  layer_out_t pending_words[$];
  int mismatch_count = 0;

  function automatic int clip16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return int'(x);
  endfunction

  function automatic int clamp_use(int v);
    if (v < 1) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  // One momentum SGD step with L2 decay; grad is at Q.28 scale.
  function automatic int sgd_param(inout int vel, input int p, input longint grad);
    longint t;
    int     stp;
    t = longint'(lr_q16) * (grad + longint'(l2_q16) * p);
    if (mom_q16 != 0) t += longint'(mom_q16) * vel * 65536;
    stp = clip16((t + (64'sd1 <<< 31)) >>> 32);
    if (mom_q16 != 0) vel = stp;
    return clip16(longint'(p) - stp);
  endfunction

  function automatic layer_out_t ack_word(logic [3:0] n);
    layer_out_t w;
    w.neuron = n; w.act = '0; w.pre = '0; w.slp = '0; w.fin = 1'b1;
    return w;
  endfunction

  // Apply one accepted request to the predictor; return its result words.
  task automatic predict_layer(input layer_req_t r, output layer_out_t outs[$]);
    int n_in, n_out, pre, a, t, lo, hi, actv, slp, ix, val;
    longint s;
    layer_out_t w;
    outs = {};
    n_in = clamp_use(n_in_reg);
    n_out = clamp_use(n_out_reg);
    val = int'(r.val);
    case (r.kind)
      REQ_FWD: begin
        if (r.idx < n_in) begin
          in_vec[r.idx] = val;
          for (int n = 0; n < 16; n++) acc[n] += longint'(wt[n*16 + r.idx]) * val;
        end
        if (r.fin) begin
          for (int n = 0; n < n_out; n++) begin
            s = acc[n] + longint'(bias[n]) * 4096;
            pre = clip16((s + 2048) >>> 12);
            if (act_kind == 0) begin
              actv = pre > 0 ? pre : 0;
              slp = pre > 0 ? 4096 : 0;
            end else begin
              a = pre < 0 ? -pre : pre;
              if (a > 32767) a = 32767;
              ix = a >> 10;
              lo = tanh_pts[ix];
              hi = tanh_pts[ix + 1];
              t = lo + int'((longint'(hi - lo) * (a & 1023) + 512) >>> 10);
              actv = pre < 0 ? -t : t;
              slp = 4096 - int'((longint'(t) * t + 2048) >>> 12);
            end
            w.neuron = n[3:0]; w.act = actv[15:0]; w.pre = pre[15:0];
            w.slp = slp[12:0]; w.fin = (n + 1 == n_out);
            outs = {outs, w};
          end
          foreach (acc[n]) acc[n] = 0;
        end
      end
      REQ_UPD: begin
        if (r.neuron < n_out) begin
          bias[r.neuron] = sgd_param(bias_vel[r.neuron], bias[r.neuron],
                                     longint'(val) * 65536);
          for (int j = 0; j < n_in; j++)
            wt[r.neuron*16 + j] = sgd_param(wt_vel[r.neuron*16 + j], wt[r.neuron*16 + j],
                                            longint'(in_vec[j]) * val * 16);
        end
        outs = {outs, ack_word(r.neuron)};
      end
      REQ_WRITE: begin
        if (r.idx == BIAS_INDEX) bias[r.neuron] = val;
        else if (r.idx < 16) wt[r.neuron*16 + r.idx] = val;
        outs = {outs, ack_word(r.neuron)};
      end
      default: ;  // unused request code: dropped, no word
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall runs, bursts with no stall, one long hold-off.
  // --------------------------------------------------------------------------
  bit hold_results = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int stall_left, free_left;
    stall_left = 0;
    free_left = 0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        // hold off long enough for the block to fill and stall its input
        res_stall = 1'b1;
        repeat (399) @(negedge clk);
        hold_results = 0;
      end else if (free_left > 0) begin
        free_left--;
        res_stall = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_stall = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        free_left = $urandom_range(20, 80);
        res_stall = 1'b0;
      end else begin
        stall_left = pick_gap();
        res_stall = stall_left > 0;
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Compare every taken word with the oldest expectation.
  always @(posedge clk) begin
    layer_out_t w;
    if (!rst && res_valid && !res_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: neuron %0d", neuron_index_res);
        mismatch_count++;
      end else begin
        w = pending_words.pop_front();
        if (neuron_index_res !== w.neuron) begin
          $error("neuron_index_res: expected %0d, got %0d", w.neuron, neuron_index_res);
          mismatch_count++;
        end
        if (activation !== w.act) begin
          $error("activation: expected %0d, got %0d", w.act, activation);
          mismatch_count++;
        end
        if (preactivation !== w.pre) begin
          $error("preactivation: expected %0d, got %0d", w.pre, preactivation);
          mismatch_count++;
        end
        if (slope !== w.slp) begin
          $error("slope: expected %0d, got %0d", w.slp, slope);
          mismatch_count++;
        end
        if (last_res !== w.fin) begin
          $error("last_res: expected %0d, got %0d", w.fin, last_res);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  bit tx_gaps = 1;

  // Offer one word from a falling edge; return at the falling edge after it
  // is taken, valid still high so back-to-back words need no extra toggle.
  task automatic send_req(input layer_req_t r);
    int gap;
    layer_out_t outs[$];
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type = r.kind;
    neuron_index = r.neuron;
    input_index = r.idx;
    value = r.val;
    last = r.fin;
    req_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    predict_layer(r, outs);
    if (r.typed) begin
      if (r.kind == REQ_UPD || r.kind == REQ_WRITE)
        pending_words = {pending_words, ack_word(r.neuron)};
    end else begin
      foreach (outs[k]) pending_words = {pending_words, outs[k]};
    end
    @(negedge clk);
  endtask

  function automatic layer_req_t mk_req(req_t k, int n, int ix, int v, bit f, bit typed);
    layer_req_t r;
    r.kind = k; r.neuron = n[3:0]; r.idx = ix[4:0]; r.val = v[15:0];
    r.fin = f; r.typed = typed;
    return r;
  endfunction

  function automatic int rand_word();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  // Wait for the last word, then let a late silent request finish.
  task automatic drain();
    req_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data[15:0];
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      CFG_STEP_SIZE:       lr_q16 = data & 16'hffff;
      CFG_MOMENTUM:        mom_q16 = data & 16'hffff;
      CFG_L2_ALPHA:        l2_q16 = data & 16'hffff;
      CFG_ACTIVATION_KIND: act_kind = data & 1;
      CFG_INPUTS_IN_USE:   n_in_reg = data & 5'h1f;
      CFG_OUTPUTS_IN_USE:  n_out_reg = data & 5'h1f;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int lr, mom, l2, kind, nin, nout);
    write_reg(CFG_STEP_SIZE, lr);
    write_reg(CFG_MOMENTUM, mom);
    write_reg(CFG_L2_ALPHA, l2);
    write_reg(CFG_ACTIVATION_KIND, kind);
    write_reg(CFG_INPUTS_IN_USE, nin);
    write_reg(CFG_OUTPUTS_IN_USE, nout);
  endtask

  // One forward vector; a broken one drops last so its sums carry on.
  task automatic send_vector(output int sent);
    int n_in, ix;
    bit broken;
    n_in = clamp_use(n_in_reg);
    broken = ($urandom_range(0, 9) == 0);
    sent = 0;
    for (int j = 0; j < n_in; j++) begin
      ix = j;
      if ($urandom_range(0, 7) == 0) ix = $urandom_range(0, 31);
      send_req(mk_req(REQ_FWD, $urandom_range(0, 15), ix, rand_word(),
                      (j == n_in - 1) && !broken, 0));
      sent++;
    end
  endtask

  task automatic random_phase(input int budget);
    int done, r, k;
    done = 0;
    while (done < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_vector(k);
        done += k;
      end else if (r < 78) begin
        send_req(mk_req(REQ_UPD, $urandom_range(0, 15), $urandom_range(0, 31),
                        rand_word(), $urandom_range(0, 1), 0));
        done++;
      end else if (r < 93) begin
        send_req(mk_req(REQ_WRITE, $urandom_range(0, 15), $urandom_range(0, 31),
                        rand_word(), $urandom_range(0, 1), 0));
        done++;
      end else begin
        // noise: unused request code, no word comes back
        send_req(mk_req(REQ_NONE, $urandom_range(0, 15), $urandom_range(0, 31),
                        rand_word(), $urandom_range(0, 1), 0));
      end
    end
  endtask

  // Directed rows: extremes, ignored writes, the unused code, a full vector.
  layer_req_t dir_rows[$];

  initial begin
    int fwd_vals[16] = '{32767, -32768, 0, 1, -1, 4096, -4096, 21845, -21846,
                         255, -256, 16384, -16384, 8, 12345, -1};
    // settings: lr, momentum, l2, kind, inputs in use, outputs in use
    int phase_regs[8][6] = '{
      '{7, 58982, 7, 0, 16, 16},
      '{65535, 0, 65535, 1, 16, 16},
      '{0, 65535, 0, 1, 1, 1},
      '{1000, 30000, 100, 0, 0, 31},
      '{20000, 0, 300, 1, 5, 8},
      '{300, 50000, 0, 0, 16, 3},
      '{65535, 65535, 65535, 0, 12, 16},
      '{4000, 10000, 2000, 1, 16, 16}};

    foreach (acc[n]) acc[n] = 0;
    foreach (wt_vel[i]) wt_vel[i] = 0;
    foreach (bias_vel[i]) bias_vel[i] = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Registers may be written during the clearing pass.
    set_regs(7, 58982, 7, 0, 16, 16);

    // Load every weight and bias so that no entry is read unwritten.
    for (int n = 0; n < 16; n++)
      for (int j = 0; j <= 16; j++)
        send_req(mk_req(REQ_WRITE, n, j, rand_word(), 0, 0));

    dir_rows = {dir_rows, mk_req(REQ_WRITE, 15, 16, -32768, 0, 1)};
    dir_rows = {dir_rows, mk_req(REQ_WRITE, 0, 0, 32767, 1, 1)};
    dir_rows = {dir_rows, mk_req(REQ_WRITE, 3, 31, 4660, 0, 1)};
    dir_rows = {dir_rows, mk_req(REQ_WRITE, 7, 17, -1, 0, 1)};
    dir_rows = {dir_rows, mk_req(REQ_NONE, 9, 5, 100, 1, 1)};
    for (int j = 0; j < 16; j++)
      dir_rows = {dir_rows, mk_req(REQ_FWD, 0, j, fwd_vals[j], j == 15, 0)};
    dir_rows = {dir_rows, mk_req(REQ_UPD, 0, 0, 32767, 0, 1)};
    dir_rows = {dir_rows, mk_req(REQ_UPD, 15, 0, -32768, 0, 1)};
    dir_rows = {dir_rows, mk_req(REQ_FWD, 0, 0, 0, 1, 0)};
    dir_rows = {dir_rows, mk_req(REQ_WRITE, 0, 16, 0, 0, 1)};
    foreach (dir_rows[i]) send_req(dir_rows[i]);

    for (int p = 0; p < 8; p++) begin
      drain();
      set_regs(phase_regs[p][0], phase_regs[p][1], phase_regs[p][2],
               phase_regs[p][3], phase_regs[p][4], phase_regs[p][5]);
      tx_gaps = (p % 3) != 2;
      // one phase starts with a long result hold-off while requests keep coming
      if (p == 7) begin
        tx_gaps = 0;
        hold_results = 1;
      end
      random_phase(8);
    end

    drain();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
